### sv/idxl_pkg.sv
// Shared types and codes for the indexed ordered list.
package idxl_pkg;

	localparam logic [2:0] MODE_APPEND      = 3'd0;
	localparam logic [2:0] MODE_INSERT      = 3'd1;
	localparam logic [2:0] MODE_REMOVE_LAST = 3'd2;
	localparam logic [2:0] MODE_REMOVE_AT   = 3'd3;
	localparam logic [2:0] MODE_FIND        = 3'd4;
	localparam logic [2:0] MODE_READ        = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0]         mode;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] read_value;
		logic [5:0]         found_position;
		logic [6:0]         element_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_PUT,
		S_SHIFT_DOWN,
		S_SEARCH,
		S_READ,
		S_FINISH
	} state_t;

endpackage

### sv/indexed_ordered_list_top.sv
// Indexed ordered list: bounded list of signed values held in one RAM.
//
// Requests enter on req (req_valid/req_ready) and each gives exactly one
// response on rsp (rsp_valid/rsp_ready). One request is worked on at a time;
// req_ready is high only while no request is in progress.
// Work per request, set by the single RAM read and write port:
//   append, insert at the count, remove last, errors, unused modes: no shift
//   insert at p below the count: entries from the tail to p move up, one RAM
//   move per cycle, then the value is written at p; remove at p below the last
//   entry: entries above p move down; find: reads from position 0 up to the first
//   match or the last entry; read at position: one RAM read
// The next request can be taken in the cycle after the response is loaded.
// The response sits in an output register: a stalled receiver holds it there
// while the next request is already being accepted and worked on; only the
// load of a second response waits for the first to be taken.
// Reset clears the element count and the response valid; the RAM contents are
// left as they are, since only positions below the count are ever read.
module indexed_ordered_list_top #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  idxl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output idxl_pkg::rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;

	idxl_pkg::state_t state_q, state_d;

	logic [CW-1:0]          count_q, count_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic [AW-1:0]          pos_q, pos_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic [2:0]             st_q, st_d;
	logic [31:0]            rd_q, rd_d;
	logic [5:0]             fp_q, fp_d;
	logic                   rsp_valid_q;
	idxl_pkg::rsp_t         rsp_q;
	logic                   load;

	logic                   we;
	logic [AW-1:0]          waddr, raddr;
	logic [VALUE_WIDTH-1:0] wdata, rdata;

	logic [VALUE_WIDTH-1:0] in_val;
	logic [PW-1:0]          pos_w, cnt_w;
	logic [AW-1:0]          last;
	logic                   full, empty;

	idxl_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_val = VALUE_WIDTH'(req.value);
	assign pos_w  = PW'(req.position);
	assign cnt_w  = PW'(count_q);
	assign last   = AW'(count_q - CW'(1));
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	assign req_ready = (state_q == idxl_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= idxl_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		pos_q <= pos_d;
		val_q <= val_d;
		st_q  <= st_d;
		rd_q  <= rd_d;
		fp_q  <= fp_d;
		if (load) begin
			rsp_q.status         <= st_q;
			rsp_q.read_value     <= rd_q;
			rsp_q.found_position <= fp_q;
			rsp_q.element_count  <= 7'(count_q);
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		val_d   = val_q;
		st_d    = st_q;
		rd_d    = rd_q;
		fp_d    = fp_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = rdata;
		raddr   = idx_q;
		load    = 1'b0;

		unique case (state_q)
			idxl_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = idxl_pkg::S_FINISH;
					pos_d   = AW'(req.position);
					val_d   = in_val;
					st_d    = idxl_pkg::ST_OK;
					rd_d    = '0;
					fp_d    = '0;
					unique case (req.mode)
						idxl_pkg::MODE_APPEND: begin
							if (full) begin
								st_d = idxl_pkg::ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = AW'(count_q);
								wdata   = in_val;
								count_d = count_q + CW'(1);
							end
						end
						idxl_pkg::MODE_INSERT: begin
							if (pos_w > cnt_w) begin
								st_d = idxl_pkg::ST_RANGE;
							end else if (full) begin
								st_d = idxl_pkg::ST_FULL;
							end else if (pos_w == cnt_w) begin
								we      = 1'b1;
								waddr   = AW'(count_q);
								wdata   = in_val;
								count_d = count_q + CW'(1);
							end else begin
								// open a gap: move entries up from the tail
								raddr   = last;
								idx_d   = last;
								state_d = idxl_pkg::S_SHIFT_UP;
							end
						end
						idxl_pkg::MODE_REMOVE_LAST: begin
							if (empty) begin
								st_d = idxl_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						idxl_pkg::MODE_REMOVE_AT: begin
							if (pos_w > cnt_w) begin
								st_d = idxl_pkg::ST_RANGE;
							end else if (empty) begin
								st_d = idxl_pkg::ST_EMPTY;
							end else if (pos_w == cnt_w) begin
								st_d = idxl_pkg::ST_RANGE;
							end else if (pos_w == cnt_w - PW'(1)) begin
								count_d = count_q - CW'(1);
							end else begin
								raddr   = AW'(req.position) + AW'(1);
								idx_d   = AW'(req.position) + AW'(1);
								state_d = idxl_pkg::S_SHIFT_DOWN;
							end
						end
						idxl_pkg::MODE_FIND: begin
							if (empty) begin
								st_d = idxl_pkg::ST_EMPTY;
							end else begin
								raddr   = '0;
								idx_d   = '0;
								state_d = idxl_pkg::S_SEARCH;
							end
						end
						idxl_pkg::MODE_READ: begin
							if (pos_w > cnt_w) begin
								st_d = idxl_pkg::ST_RANGE;
							end else if (empty) begin
								st_d = idxl_pkg::ST_EMPTY;
							end else if (pos_w == cnt_w) begin
								st_d = idxl_pkg::ST_RANGE;
							end else begin
								raddr   = AW'(req.position);
								state_d = idxl_pkg::S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			idxl_pkg::S_SHIFT_UP: begin
				we    = 1'b1;
				waddr = idx_q + AW'(1);
				wdata = rdata;
				if (idx_q == pos_q) begin
					state_d = idxl_pkg::S_PUT;
				end else begin
					raddr = idx_q - AW'(1);
					idx_d = idx_q - AW'(1);
				end
			end
			idxl_pkg::S_PUT: begin
				we      = 1'b1;
				waddr   = pos_q;
				wdata   = val_q;
				count_d = count_q + CW'(1);
				state_d = idxl_pkg::S_FINISH;
			end
			idxl_pkg::S_SHIFT_DOWN: begin
				we    = 1'b1;
				waddr = idx_q - AW'(1);
				wdata = rdata;
				if (idx_q == last) begin
					count_d = count_q - CW'(1);
					state_d = idxl_pkg::S_FINISH;
				end else begin
					raddr = idx_q + AW'(1);
					idx_d = idx_q + AW'(1);
				end
			end
			idxl_pkg::S_SEARCH: begin
				if (rdata == val_q) begin
					fp_d    = 6'(idx_q);
					state_d = idxl_pkg::S_FINISH;
				end else if (idx_q == last) begin
					st_d    = idxl_pkg::ST_NOTFOUND;
					state_d = idxl_pkg::S_FINISH;
				end else begin
					raddr = idx_q + AW'(1);
					idx_d = idx_q + AW'(1);
				end
			end
			idxl_pkg::S_READ: begin
				rd_d    = 32'(rdata);
				state_d = idxl_pkg::S_FINISH;
			end
			idxl_pkg::S_FINISH: begin
				// hold until the output register is free or being drained
				if (!rsp_valid_q || rsp_ready) begin
					load    = 1'b1;
					state_d = idxl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = idxl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### sv/idxl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module idxl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/idxl_checker.sv
// Port-level checks for the indexed ordered list, bound to the top level.
module idxl_checker #(
	parameter int CAPACITY = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input idxl_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input idxl_pkg::rsp_t rsp
);

	// hold a waiting request
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("waiting request changed");

	// hold a stalled response
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one request in flight: no accept in the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// failed requests carry zero data fields
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != idxl_pkg::ST_OK |->
			rsp.read_value == '0 && rsp.found_position == '0)
		else $error("data field set on failed request");

	// full is reported only at capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == idxl_pkg::ST_FULL |->
			rsp.element_count == 7'(CAPACITY))
		else $error("full reported below capacity");

endmodule

bind indexed_ordered_list_top idxl_checker #(
	.CAPACITY(CAPACITY)
) u_idxl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
